>>> src/vefd_pkg.sv
// vefd_pkg: shared constants, types and the seed table for the v210 dither unit.
// No dependencies; every other file refers to it by scoped names.
package vefd_pkg;

  localparam int WORD_W       = 32;
  localparam int SAMPLE_W     = 10;
  localparam int OUT_W        = 8;
  localparam int ERR_W        = 2;
  localparam int PHASE_W      = 2;
  localparam int SEED_ADDR_W  = 5;
  localparam int SEED_LEN_DEF = 32;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 10'h3ff;

  typedef enum logic [1:0] {
    COMP_Y,
    COMP_U,
    COMP_V
  } comp_t;

  typedef logic [ERR_W-1:0] err_t;

  localparam err_t SEED_TABLE [32] = '{
    2'd2, 2'd3, 2'd0, 2'd0, 2'd3, 2'd1, 2'd2, 2'd3,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd0, 2'd1, 2'd0, 2'd3,
    2'd0, 2'd2, 2'd3, 2'd0, 2'd0, 2'd3, 2'd1, 2'd1,
    2'd0, 2'd3, 2'd3, 2'd1, 2'd2, 2'd2, 2'd3, 2'd2
  };

  // Component carried by sample slot k of the word at a given group phase.
  function automatic comp_t comp_of(input logic [PHASE_W-1:0] phase, input logic [1:0] k);
    comp_t c;
    c = COMP_Y;
    case (phase)
      2'd0: c = (k == 2'd0) ? COMP_U : ((k == 2'd1) ? COMP_Y : COMP_V);
      2'd1: c = (k == 2'd1) ? COMP_U : COMP_Y;
      2'd2: c = (k == 2'd0) ? COMP_V : ((k == 2'd1) ? COMP_Y : COMP_U);
      2'd3: c = (k == 2'd1) ? COMP_V : COMP_Y;
      default: c = COMP_Y;
    endcase
    return c;
  endfunction

endpackage

>>> src/vefd_if.sv
// vefd_if: valid/ready channel interfaces for input words, results and config.
// Depends on vefd_pkg for field widths.
interface vefd_in_if;
  logic                              valid;
  logic                              ready;
  logic [vefd_pkg::WORD_W-1:0]       packed_word;
  logic                              line_start;
  logic                              frame_start;
  modport source (output valid, packed_word, line_start, frame_start, input ready);
  modport sink   (input valid, packed_word, line_start, frame_start, output ready);
endinterface

interface vefd_out_if;
  logic                              valid;
  logic                              ready;
  logic [vefd_pkg::OUT_W-1:0]        sample_a;
  logic [vefd_pkg::OUT_W-1:0]        sample_b;
  logic [vefd_pkg::OUT_W-1:0]        sample_c;
  modport source (output valid, sample_a, sample_b, sample_c, input ready);
  modport sink   (input valid, sample_a, sample_b, sample_c, output ready);
endinterface

interface vefd_cfg_if;
  logic valid;
  logic ready;
  logic dither_enable;
  modport source (output valid, dither_enable, input ready);
  modport sink   (input valid, dither_enable, output ready);
endinterface

>>> src/vefd_seed_gen.sv
// vefd_seed_gen: line-start seed lookup and seed index advance.
// Depends on vefd_pkg for the seed table.
module vefd_seed_gen #(
  parameter int SEED_LEN = vefd_pkg::SEED_LEN_DEF,
  parameter int IDX_W    = 5
) (
  input  logic [IDX_W-1:0]   idx,
  input  logic               frame_start,
  output vefd_pkg::err_t     seed_y,
  output vefd_pkg::err_t     seed_u,
  output vefd_pkg::err_t     seed_v,
  output logic [IDX_W-1:0]   idx_nxt
);

  localparam logic [IDX_W-1:0] LAST = IDX_W'(SEED_LEN - 1);

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] x);
    return (x == LAST) ? '0 : x + 1'b1;
  endfunction

  logic [IDX_W-1:0] i0, i1, i2;

  always_comb begin
    i0      = frame_start ? '0 : idx;
    i1      = wrap_inc(i0);
    i2      = wrap_inc(i1);
    idx_nxt = wrap_inc(i2);
    // table holds 32 entries; longer seed lengths repeat them
    seed_y  = vefd_pkg::SEED_TABLE[vefd_pkg::SEED_ADDR_W'(i0)];
    seed_u  = vefd_pkg::SEED_TABLE[vefd_pkg::SEED_ADDR_W'(i1)];
    seed_v  = vefd_pkg::SEED_TABLE[vefd_pkg::SEED_ADDR_W'(i2)];
  end

endmodule

>>> src/vefd_datapath.sv
// vefd_datapath: per-word error feedback on three 10-bit samples.
// Depends on vefd_pkg for widths, component codes and the phase map.
module vefd_datapath (
  input  logic [vefd_pkg::WORD_W-1:0]  word,
  input  logic [vefd_pkg::PHASE_W-1:0] phase,
  input  logic                         dither_en,
  input  vefd_pkg::err_t               err_y,
  input  vefd_pkg::err_t               err_u,
  input  vefd_pkg::err_t               err_v,
  output logic [vefd_pkg::OUT_W-1:0]   sample [3],
  output vefd_pkg::err_t               err_y_nxt,
  output vefd_pkg::err_t               err_u_nxt,
  output vefd_pkg::err_t               err_v_nxt
);

  always_comb begin
    logic [vefd_pkg::SAMPLE_W-1:0] s;
    logic [vefd_pkg::SAMPLE_W:0]   sum;
    logic [vefd_pkg::SAMPLE_W-1:0] sat;
    vefd_pkg::err_t                e;
    vefd_pkg::comp_t               c;
    err_y_nxt = err_y;
    err_u_nxt = err_u;
    err_v_nxt = err_v;
    for (int k = 0; k < 3; k++) begin
      s = word[k*vefd_pkg::SAMPLE_W +: vefd_pkg::SAMPLE_W];
      c = vefd_pkg::comp_of(phase, 2'(k));
      case (c)
        vefd_pkg::COMP_Y: e = err_y_nxt;
        vefd_pkg::COMP_U: e = err_u_nxt;
        vefd_pkg::COMP_V: e = err_v_nxt;
        default:          e = err_y_nxt;
      endcase
      sum = {1'b0, s} + {{(vefd_pkg::SAMPLE_W + 1 - vefd_pkg::ERR_W){1'b0}}, e};
      sat = sum[vefd_pkg::SAMPLE_W] ? vefd_pkg::SAMPLE_MAX : sum[vefd_pkg::SAMPLE_W-1:0];
      if (dither_en) begin
        sample[k] = sat[vefd_pkg::SAMPLE_W-1:vefd_pkg::ERR_W];
        case (c)
          vefd_pkg::COMP_Y: err_y_nxt = sat[vefd_pkg::ERR_W-1:0];
          vefd_pkg::COMP_U: err_u_nxt = sat[vefd_pkg::ERR_W-1:0];
          vefd_pkg::COMP_V: err_v_nxt = sat[vefd_pkg::ERR_W-1:0];
          default:          err_y_nxt = sat[vefd_pkg::ERR_W-1:0];
        endcase
      end else begin
        sample[k] = s[vefd_pkg::SAMPLE_W-1:vefd_pkg::ERR_W];
      end
    end
  end

endmodule

>>> src/v210_error_feedback_dither_unit.sv
// v210_error_feedback_dither_unit: v210 10-bit to 8-bit error feedback dither.
// Pipeline: input register, then result register, between input transfer and result valid.
// Throughput: one word per cycle without output backpressure; the error/phase/seed
// state loop closes through the datapath between the input and result registers.
// Reset (rst_n low, synchronous): pipeline empty, errors/phase/seed index zero,
// dither enabled.
module v210_error_feedback_dither_unit #(
  parameter int SEED_LEN = vefd_pkg::SEED_LEN_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  vefd_in_if.sink        in_stream,
  vefd_out_if.source     out_stream,
  vefd_cfg_if.sink       cfg_write
);

  localparam int IDX_W = (SEED_LEN > 1) ? $clog2(SEED_LEN) : 1;

  // Mode register; to be written only while the block is idle (not enforced by the block).
  logic dither_en_r;

  // Input stage.
  logic                          s1_valid_r;
  logic [vefd_pkg::WORD_W-1:0]   s1_word_r;
  logic                          s1_line_r;
  logic                          s1_frame_r;

  // Running state.
  vefd_pkg::err_t                err_y_r, err_u_r, err_v_r;
  logic [vefd_pkg::PHASE_W-1:0]  phase_r;
  logic [IDX_W-1:0]              seed_idx_r;

  // Result stage.
  logic                          out_valid_r;
  logic [vefd_pkg::OUT_W-1:0]    out_a_r, out_b_r, out_c_r;

  logic s1_advance;
  logic s1_fire;
  logic in_xfer;

  // The input stage moves on whenever the result register is free or is
  // being drained this cycle, so backpressure only stalls a full pipeline.
  assign s1_advance = !out_valid_r || out_stream.ready;
  assign s1_fire    = s1_valid_r && s1_advance;
  assign in_stream.ready = !s1_valid_r || s1_advance;
  assign in_xfer    = in_stream.valid && in_stream.ready;

  assign cfg_write.ready = 1'b1;

  // Seed lookup for a line start (frame start implies line start).
  vefd_pkg::err_t   seed_y, seed_u, seed_v;
  logic [IDX_W-1:0] seed_idx_nxt;
  logic             line_any;

  assign line_any = s1_line_r || s1_frame_r;

  vefd_seed_gen #(
    .SEED_LEN (SEED_LEN),
    .IDX_W    (IDX_W)
  ) u_seed (
    .idx         (seed_idx_r),
    .frame_start (s1_frame_r),
    .seed_y      (seed_y),
    .seed_u      (seed_u),
    .seed_v      (seed_v),
    .idx_nxt     (seed_idx_nxt)
  );

  // Effective state for this word: seeds and phase zero on a line start.
  vefd_pkg::err_t               eff_y, eff_u, eff_v;
  logic [vefd_pkg::PHASE_W-1:0] eff_phase;

  assign eff_y     = line_any ? seed_y : err_y_r;
  assign eff_u     = line_any ? seed_u : err_u_r;
  assign eff_v     = line_any ? seed_v : err_v_r;
  assign eff_phase = line_any ? '0 : phase_r;

  logic [vefd_pkg::OUT_W-1:0] dp_sample [3];
  vefd_pkg::err_t             err_y_nxt, err_u_nxt, err_v_nxt;

  vefd_datapath u_dp (
    .word      (s1_word_r),
    .phase     (eff_phase),
    .dither_en (dither_en_r),
    .err_y     (eff_y),
    .err_u     (eff_u),
    .err_v     (eff_v),
    .sample    (dp_sample),
    .err_y_nxt (err_y_nxt),
    .err_u_nxt (err_u_nxt),
    .err_v_nxt (err_v_nxt)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dither_en_r <= 1'b1;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      err_y_r     <= '0;
      err_u_r     <= '0;
      err_v_r     <= '0;
      phase_r     <= '0;
      seed_idx_r  <= '0;
    end else begin
      if (cfg_write.valid) begin
        dither_en_r <= cfg_write.dither_enable;
      end
      // hold the input stage when stalled, refill or drain it otherwise
      if (in_stream.ready) begin
        s1_valid_r <= in_stream.valid;
      end
      if (s1_advance) begin
        out_valid_r <= s1_valid_r;
      end
      // advance running state once per word handed to the result register
      if (s1_fire) begin
        err_y_r <= err_y_nxt;
        err_u_r <= err_u_nxt;
        err_v_r <= err_v_nxt;
        phase_r <= eff_phase + 1'b1;
        if (line_any) begin
          seed_idx_r <= seed_idx_nxt;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_word_r  <= in_stream.packed_word;
      s1_line_r  <= in_stream.line_start;
      s1_frame_r <= in_stream.frame_start;
    end
    if (s1_fire) begin
      out_a_r <= dp_sample[0];
      out_b_r <= dp_sample[1];
      out_c_r <= dp_sample[2];
    end
  end

  assign out_stream.valid    = out_valid_r;
  assign out_stream.sample_a = out_a_r;
  assign out_stream.sample_b = out_b_r;
  assign out_stream.sample_c = out_c_r;

endmodule

>>> src/vefd_checker.sv
// vefd_checker: port-level assertions for the v210 dither unit, plus its bind.
// Depends on vefd_pkg for the result width.
module vefd_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [vefd_pkg::OUT_W-1:0]   out_a,
  input logic [vefd_pkg::OUT_W-1:0]   out_b,
  input logic [vefd_pkg::OUT_W-1:0]   out_c,
  input logic                         cfg_valid,
  input logic                         cfg_ready
);

  // after an input transfer, out_valid must be high once the word has passed both registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> ##1 out_valid)
    else $error("result missing two cycles after input transfer");

  // input only stalls when the result side is full and backpressured
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output backpressure");

  // configuration writes are always taken
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("config write refused");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_a) && $stable(out_b)
                                   && $stable(out_c)))
    else $error("stalled result changed");

endmodule

bind v210_error_feedback_dither_unit vefd_checker u_vefd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_stream.valid),
  .in_ready  (in_stream.ready),
  .out_valid (out_stream.valid),
  .out_ready (out_stream.ready),
  .out_a     (out_stream.sample_a),
  .out_b     (out_stream.sample_b),
  .out_c     (out_stream.sample_c),
  .cfg_valid (cfg_write.valid),
  .cfg_ready (cfg_write.ready)
);
